// ===== hdl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the positional list block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define ASSERT_SYNC(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked at every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/plid_pkg.sv =====
// ----------------------------------------------------------------------------
// plid_pkg
// Types and codes shared by the positional list controller and datapath.
// ----------------------------------------------------------------------------
package plid_pkg;

  localparam int unsigned KIND_W   = 2;
  localparam int unsigned POS_W    = 8;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned LEN_W    = 5;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_DUMP   = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_STREAM
  } state_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic stream;
  } ctrl_cmd_t;

  typedef struct packed {
    logic stream_pend;
    logic last_word;
  } dp_stat_t;

endpackage

// ===== hdl/plid_ctrl.sv =====
// ----------------------------------------------------------------------------
// plid_ctrl
// Sequencer that captures a command, executes it and streams dump words.
// ----------------------------------------------------------------------------
module plid_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  plid_pkg::dp_stat_t   stat,
  output plid_pkg::ctrl_cmd_t  cmd,
  output logic                 busy
);
  import plid_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state_r)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (stat.stream_pend) begin
          state_nxt = S_STREAM;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_STREAM: begin
        cmd.stream = 1'b1;
        if (stat.last_word) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hdl/plid_datapath.sv =====
// ----------------------------------------------------------------------------
// plid_datapath
// Cell chain with count, per-lane shift logic and registered result word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module plid_datapath #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  plid_pkg::ctrl_cmd_t                cmd,
  input  logic [plid_pkg::KIND_W-1:0]        in_kind,
  input  logic [plid_pkg::POS_W-1:0]         in_position,
  input  logic signed [plid_pkg::DATA_W-1:0] in_value,
  output plid_pkg::dp_stat_t                 stat,
  output logic                               out_valid,
  output logic [plid_pkg::STATUS_W-1:0]      out_status,
  output logic signed [plid_pkg::DATA_W-1:0] out_element,
  output logic [plid_pkg::LEN_W-1:0]         out_length,
  output logic                               out_last
);
  import plid_pkg::*;

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = POS_W + 1;

  logic [KIND_W-1:0]        kind_r;
  logic [POS_W-1:0]         pos_r;
  logic signed [DATA_W-1:0] value_r;
  logic [DATA_W-1:0]        cells_r [CAPACITY];
  logic [CW-1:0]            count_r;
  logic [CW-1:0]            count_nxt;
  logic [IW-1:0]            idx_r;

  logic                     out_valid_r;
  logic [STATUS_W-1:0]      out_status_r;
  logic signed [DATA_W-1:0] out_element_r;
  logic [LEN_W-1:0]         out_length_r;
  logic                     out_last_r;

  status_t       op_status;
  logic          do_ins;
  logic          do_del;
  logic          stream_pend;
  logic          last_word;
  logic [PW-1:0] pos9;
  logic [PW-1:0] cnt9;
  logic [PW-1:0] p0;

  assign pos9 = {1'b0, pos_r};
  assign cnt9 = PW'(count_r);
  assign p0   = pos9 - PW'(1);

  always_comb begin
    op_status   = ST_OK;
    count_nxt   = count_r;
    do_ins      = 1'b0;
    do_del      = 1'b0;
    stream_pend = 1'b0;
    priority if (kind_r == KIND_INSERT) begin
      priority if (pos9 == '0 || pos9 > cnt9 + PW'(1)) begin
        op_status = ST_INVALID;
      end else if (cnt9 >= PW'(CAPACITY)) begin
        op_status = ST_FULL;
      end else begin
        do_ins    = 1'b1;
        count_nxt = count_r + CW'(1);
      end
    end else if (kind_r == KIND_DELETE) begin
      priority if (count_r == '0) begin
        op_status = ST_EMPTY;
      end else if (pos9 == '0 || pos9 > cnt9) begin
        op_status = ST_INVALID;
      end else begin
        do_del    = 1'b1;
        count_nxt = count_r - CW'(1);
      end
    end else if (kind_r == KIND_DUMP) begin
      if (count_r == '0) begin
        op_status = ST_EMPTY;
      end else begin
        stream_pend = 1'b1;
      end
    end else begin
      op_status = ST_INVALID;
    end
  end

  assign last_word        = (CW'(idx_r) + CW'(1)) == count_r;
  assign stat.stream_pend = stream_pend;
  assign stat.last_word   = last_word;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      pos_r   <= in_position;
      value_r <= in_value;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.exec) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      idx_r <= '0;
    end else if (cmd.stream) begin
      idx_r <= idx_r + IW'(1);
    end
  end

  for (genvar g = 0; g < CAPACITY; g++) begin : g_lane
    logic [DATA_W-1:0] prev_w;
    logic [DATA_W-1:0] next_w;
    logic [DATA_W-1:0] cell_nxt;

    if (g == 0) begin : g_head
      assign prev_w = '0;
    end else begin : g_body_prev
      assign prev_w = cells_r[g-1];
    end

    if (g == CAPACITY - 1) begin : g_tail
      assign next_w = '0;
    end else begin : g_body_next
      assign next_w = cells_r[g+1];
    end

    always_comb begin
      cell_nxt = cells_r[g];
      priority if (cmd.exec && do_ins) begin
        if (PW'(g) == p0) begin
          cell_nxt = value_r;
        end else if (PW'(g) > p0 && PW'(g) <= cnt9) begin
          cell_nxt = prev_w;
        end
      end else if (cmd.exec && do_del) begin
        if (PW'(g) >= p0 && PW'(g) + PW'(1) < cnt9) begin
          cell_nxt = next_w;
        end
      end else if (cmd.stream) begin
        if (PW'(g) + PW'(1) == cnt9) begin
          cell_nxt = cells_r[0];
        end else if (PW'(g) + PW'(1) < cnt9) begin
          cell_nxt = next_w;
        end
      end else begin
        cell_nxt = cells_r[g];
      end
    end

    always_ff @(posedge clk) begin
      cells_r[g] <= cell_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= (cmd.exec && !stream_pend) || cmd.stream;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.stream) begin
      out_status_r  <= ST_OK;
      out_element_r <= cells_r[0];
      out_length_r  <= LEN_W'(count_r);
      out_last_r    <= last_word;
    end else begin
      out_status_r  <= op_status;
      out_element_r <= '0;
      out_length_r  <= LEN_W'(count_nxt);
      out_last_r    <= 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_element = out_element_r;
  assign out_length  = out_length_r;
  assign out_last    = out_last_r;

  `ASSERT_SYNC(a_count_bound, clk, rst_n, (count_r <= CW'(CAPACITY)), "count above capacity")
  `ASSERT_SYNC(a_count_by_exec, clk, rst_n, (count_r != $past(count_r) |-> $past(cmd.exec)), "count changed outside execute")
  `ASSERT_SYNC(a_stream_ok, clk, rst_n, (out_valid_r && !out_last_r |-> out_status_r == ST_OK), "non-final word without ok status")
  `ASSERT_ALWAYS(a_one_cmd, clk, $onehot0({cmd.load, cmd.exec, cmd.stream}), "more than one command active")

endmodule

// ===== hdl/positional_list_insert_delete.sv =====
// Insert, delete, kind 3 and empty dump: the single result strobes, registered from the execute state.
// Start is taken again, in the idle state, while that result strobes.
// A dump of n elements strobes n words, registered from the stream state after execute.
// Streaming rotates the cell chain one element per cycle; each word is the head cell.
// Synchronous reset empties the list; cell contents stay undefined until written.
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Bounded ordered list with insert and delete at a 1-based position and dump.
// ----------------------------------------------------------------------------
module positional_list_insert_delete #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  output logic                               busy,
  input  logic [plid_pkg::KIND_W-1:0]        in_kind,
  input  logic [plid_pkg::POS_W-1:0]         in_position,
  input  logic signed [plid_pkg::DATA_W-1:0] in_value,
  output logic                               out_valid,
  output logic [plid_pkg::STATUS_W-1:0]      out_status,
  output logic signed [plid_pkg::DATA_W-1:0] out_element,
  output logic [plid_pkg::LEN_W-1:0]         out_length,
  output logic                               out_last
);
  import plid_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;

  plid_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  plid_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .in_kind     (in_kind),
    .in_position (in_position),
    .in_value    (in_value),
    .stat        (stat),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_element (out_element),
    .out_length  (out_length),
    .out_last    (out_last)
  );

endmodule
